// ===== hw/rtl/bb3_pkg.sv =====
`default_nettype none
package bb3_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 2048;
  localparam int LINE_AW   = $clog2(MAX_WIDTH);
  localparam int WEFF_W    = LINE_AW + 1;

  // configuration registers
  localparam int DIM_W  = 12;
  localparam int CMP_W  = ((DIM_W > WEFF_W) ? DIM_W : WEFF_W) + 1;
  localparam int CFG_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // results and buffering
  localparam int MAX_RESULTS = 4;
  localparam int K_W         = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = FIFO_AW + 1;

  // arithmetic
  localparam int SUM_W  = 12;
  localparam int MUL_W  = 16;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV3_MUL = 16'd43691;
  localparam int DIV3_SH = 17;
  localparam logic [MUL_W-1:0] DIV9_MUL = 16'd58255;
  localparam int DIV9_SH = 19;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       run_last;
    logic       frame_done;
  } out_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // one line store entry: two rows above the current one
  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_t;

  // new window column, oldest row first
  typedef struct packed {
    pixel_t above2;
    pixel_t above1;
    pixel_t pix;
  } win_col_t;

  typedef struct packed {
    logic [WEFF_W-1:0] w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              restart;
  } cfg_t;

  // one result to compute from the window
  typedef struct packed {
    logic valid;
    logic dc_off;
    logic dr_off;
    logic top_ok;
    logic left_ok;
    logic last;
  } job_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [3:0]       n;
    logic             last;
    logic             done;
  } sum_t;

  // (2*sum + n) / (2*n) == (sum + n/2) / n, by reciprocal for 3, 6 and 9
  function automatic logic [7:0] mean_div(input logic [SUM_W-1:0] sum,
                                          input logic [3:0] n);
    logic [SUM_W-1:0]  x;
    logic [PROD_W-1:0] prod;
    logic [7:0]        q;
    x    = sum + SUM_W'(n >> 1);
    prod = '0;
    q    = '0;
    case (n)
      4'd1: q = x[7:0];
      4'd2: q = x[8:1];
      4'd4: q = x[9:2];
      4'd3: begin
        prod = PROD_W'(x) * PROD_W'(DIV3_MUL);
        q    = prod[DIV3_SH +: 8];
      end
      4'd6: begin
        prod = PROD_W'(x >> 1) * PROD_W'(DIV3_MUL);
        q    = prod[DIV3_SH +: 8];
      end
      4'd9: begin
        prod = PROD_W'(x) * PROD_W'(DIV9_MUL);
        q    = prod[DIV9_SH +: 8];
      end
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/box_blur_3x3_edge_normalized_top.sv =====
`default_nettype none
// 3x3 box blur of an rgb pixel stream, mean taken over the neighbours that lie
// inside the frame and rounded half up. pixels enter in raster order; results
// come out one row and one column behind, with extra results at row ends, in
// the last row (interleaved with the row above) and at the final pixel. the
// two rows above the current one live in one line store, one entry per column,
// read at accept and written back in the following cycle. a pixel causing at
// most one result is taken every clock; one causing k results (2 at a row end,
// up to 4 in the last row) holds the input while the window hands them one per
// cycle to the adders. results wait in a 16-item fifo and input also stalls
// when the results already promised would overflow it. the first result of a
// pixel is offered after the line store stage, the result sequencer, the adder
// register and the fifo. no clearing pass is run after reset. a write to either
// register restarts the frame at pixel (0,0).
module box_blur_3x3_edge_normalized_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bb3_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bb3_pkg::APB_DW-1:0]  pwdata,
  output logic      [bb3_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        pix_valid,
  output logic                             pix_stall,
  input  wire bb3_pkg::in_t                pix,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output bb3_pkg::out_t                    res
);

  localparam int ROW_CW = bb3_pkg::DIM_W + 1;
  localparam int RESV_W = bb3_pkg::CNT_W + 1;

  // where the current pixel sits relative to the frame edges
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } pos_t;

  bb3_pkg::cfg_t cfg;

  // raster position of the next pixel
  logic [bb3_pkg::LINE_AW-1:0] col;
  logic [bb3_pkg::DIM_W-1:0]   row;

  pos_t                   pos_now;
  logic [1:0]             ncol;
  logic [1:0]             nrow;
  logic [bb3_pkg::K_W-1:0] k_now;

  // handshake bookkeeping
  logic                   accept;
  logic                   pop;
  logic [1:0]             hold;
  logic [bb3_pkg::CNT_W-1:0] resv;
  logic [RESV_W-1:0]      resv_sum;

  // stage after accept: line store data returns here
  logic                        s1_valid;
  logic [bb3_pkg::LINE_AW-1:0] s1_col;
  bb3_pkg::pixel_t             s1_pix;
  pos_t                        s1_pos;
  logic [bb3_pkg::K_W-1:0]     s1_k;

  bb3_pkg::line_t    ram_q;
  bb3_pkg::line_t    line_rd;
  bb3_pkg::line_t    wr_data;
  logic              fwd_hit;
  bb3_pkg::line_t    fwd_data;
  bb3_pkg::win_col_t column;

  // result sequencer
  logic [bb3_pkg::K_W-1:0] g_left;
  logic [1:0]              g_idx;
  pos_t                    g_pos;
  logic                    nrow2;
  logic                    ci;
  logic                    ri;
  bb3_pkg::job_t           job;
  bb3_pkg::sum_t           sum;

  assign pready = 1'b1;

  bb3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // edge flags and result count for the pixel about to be taken
  always_comb begin
    pos_now.c_ge1  = (col != '0);
    pos_now.c_ge2  = (col > bb3_pkg::LINE_AW'(1));
    pos_now.c_last = ((bb3_pkg::WEFF_W'(col) + bb3_pkg::WEFF_W'(1)) == cfg.w_eff);
    pos_now.r_ge1  = (row != '0);
    pos_now.r_ge2  = (row > bb3_pkg::DIM_W'(1));
    pos_now.r_last = ((ROW_CW'(row) + ROW_CW'(1)) == ROW_CW'(cfg.h_eff));
    ncol  = {1'b0, pos_now.c_ge1} + {1'b0, pos_now.c_last};
    nrow  = {1'b0, pos_now.r_ge1} + {1'b0, pos_now.r_last};
    k_now = bb3_pkg::K_W'({1'b0, ncol} * {1'b0, nrow});
  end

  // stall while the window must keep still for earlier results, or while
  // the fifo has no room for every result this pixel would cause
  assign resv_sum  = RESV_W'(resv) + RESV_W'(k_now);
  assign pix_stall = (hold != 2'd0) || (resv_sum > RESV_W'(bb3_pkg::FIFO_DEPTH));
  assign accept    = pix_valid && !pix_stall;
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg.restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (pos_now.c_last) begin
        col <= '0;
        row <= pos_now.r_last ? '0 : row + bb3_pkg::DIM_W'(1);
      end else begin
        col <= col + bb3_pkg::LINE_AW'(1);
      end
    end
  end

  // hold covers the cycles in which the sequencer still reads the window
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 2'd0;
      resv <= '0;
    end else begin
      if (accept) begin
        hold <= (k_now > bb3_pkg::K_W'(1)) ? 2'(k_now - bb3_pkg::K_W'(1)) : 2'd0;
      end else if (hold != 2'd0) begin
        hold <= hold - 2'd1;
      end
      resv <= resv + (accept ? bb3_pkg::CNT_W'(k_now) : '0) - bb3_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_col       <= col;
      s1_pix.red   <= pix.in_red;
      s1_pix.green <= pix.in_green;
      s1_pix.blue  <= pix.in_blue;
      s1_pos       <= pos_now;
      s1_k         <= k_now;
    end
  end

  bb3_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram_q),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // a one-pixel-wide frame reads the entry that is written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= accept && s1_valid && (s1_col == col);
    end
    fwd_data <= wr_data;
  end

  always_comb begin
    line_rd        = fwd_hit ? fwd_data : ram_q;
    wr_data.older  = line_rd.newer;
    wr_data.newer  = s1_pix;
    column.above2  = line_rd.older;
    column.above1  = line_rd.newer;
    column.pix     = s1_pix;
  end

  // results of one pixel go out one per cycle, by column then by row
  always_ff @(posedge clk) begin
    if (rst) begin
      g_left <= '0;
    end else if (s1_valid) begin
      g_left <= s1_k;
    end else if (g_left != '0) begin
      g_left <= g_left - bb3_pkg::K_W'(1);
    end
    if (s1_valid) begin
      g_idx <= 2'd0;
      g_pos <= s1_pos;
    end else if (g_left != '0) begin
      g_idx <= g_idx + 2'd1;
    end
  end

  // offset 1 means the result one column or row behind the newest pixel
  always_comb begin
    nrow2       = g_pos.r_ge1 && g_pos.r_last;
    ci          = nrow2 ? g_idx[1] : g_idx[0];
    ri          = nrow2 ? g_idx[0] : 1'b0;
    job.valid   = (g_left != '0);
    job.dc_off  = g_pos.c_ge1 && !ci;
    job.dr_off  = g_pos.r_ge1 && !ri;
    job.top_ok  = job.dr_off ? g_pos.r_ge2 : g_pos.r_ge1;
    job.left_ok = job.dc_off ? g_pos.c_ge2 : g_pos.c_ge1;
    job.last    = (g_left == bb3_pkg::K_W'(1));
  end

  bb3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (s1_valid),
    .column (column),
    .job    (job),
    .sum    (sum)
  );

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .sum       (sum),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bb3_cfg.sv =====
`default_nettype none
module bb3_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bb3_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [bb3_pkg::APB_DW-1:0]    pwdata,
  output logic      [bb3_pkg::APB_DW-1:0]    prdata,
  output bb3_pkg::cfg_t                      cfg
);

  logic [bb3_pkg::DIM_W-1:0] frame_width;
  logic [bb3_pkg::DIM_W-1:0] frame_height;
  logic                      wr;
  logic [0:0]                idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[bb3_pkg::CFG_AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::WIDTH_RESET;
      frame_height <= bb3_pkg::HEIGHT_RESET;
    end else if (wr) begin
      unique case (idx)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[bb3_pkg::DIM_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[bb3_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bb3_pkg::REG_FRAME_WIDTH:  prdata = bb3_pkg::APB_DW'(frame_width);
      bb3_pkg::REG_FRAME_HEIGHT: prdata = bb3_pkg::APB_DW'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  // zero width or height means one, width clamps at the line store depth
  always_comb begin
    if (frame_width == '0) begin
      cfg.w_eff = bb3_pkg::WEFF_W'(1);
    end else if (bb3_pkg::CMP_W'(frame_width) > bb3_pkg::CMP_W'(bb3_pkg::MAX_WIDTH)) begin
      cfg.w_eff = bb3_pkg::WEFF_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      cfg.w_eff = bb3_pkg::WEFF_W'(frame_width);
    end
    cfg.h_eff   = (frame_height == '0) ? bb3_pkg::DIM_W'(1) : frame_height;
    cfg.restart = wr;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bb3_line_ram.sv =====
`default_nettype none
module bb3_line_ram (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [bb3_pkg::LINE_AW-1:0]  rd_addr,
  output bb3_pkg::line_t                    rd_data,
  input  wire logic                         wr_en,
  input  wire logic [bb3_pkg::LINE_AW-1:0]  wr_addr,
  input  wire bb3_pkg::line_t               wr_data
);

  bb3_pkg::line_t mem [bb3_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bb3_window.sv =====
`default_nettype none
module bb3_window (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              shift,
  input  wire bb3_pkg::win_col_t column,
  input  wire bb3_pkg::job_t     job,
  output bb3_pkg::sum_t          sum
);

  // index row*3 + col, row 0 oldest, col 2 newest
  bb3_pkg::pixel_t win [9];

  logic [2:0]      rm;
  logic [2:0]      cm;
  logic [8:0][7:0] red_v;
  logic [8:0][7:0] green_v;
  logic [8:0][7:0] blue_v;

  function automatic logic [bb3_pkg::SUM_W-1:0] chan_sum(input logic [8:0][7:0] v,
                                                         input logic [2:0] rmask,
                                                         input logic [2:0] cmask);
    logic [bb3_pkg::SUM_W-1:0] row_sum [3];
    logic [bb3_pkg::SUM_W-1:0] total;
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = (cmask[0] ? bb3_pkg::SUM_W'(v[i*3])   : '0)
                 + (cmask[1] ? bb3_pkg::SUM_W'(v[i*3+1]) : '0)
                 + (cmask[2] ? bb3_pkg::SUM_W'(v[i*3+2]) : '0);
    end
    total = (rmask[0] ? row_sum[0] : '0)
          + (rmask[1] ? row_sum[1] : '0)
          + (rmask[2] ? row_sum[2] : '0);
    return total;
  endfunction

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]   <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= column.above2;
      win[5] <= column.above1;
      win[8] <= column.pix;
    end
  end

  // newest row and column always count; the far side only where inside the frame
  always_comb begin
    rm[2] = 1'b1;
    rm[1] = job.dr_off ? 1'b1 : job.top_ok;
    rm[0] = job.dr_off ? job.top_ok : 1'b0;
    cm[2] = 1'b1;
    cm[1] = job.dc_off ? 1'b1 : job.left_ok;
    cm[0] = job.dc_off ? job.left_ok : 1'b0;
    for (int i = 0; i < 9; i++) begin
      red_v[i]   = win[i].red;
      green_v[i] = win[i].green;
      blue_v[i]  = win[i].blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum.valid <= 1'b0;
    end else begin
      sum.valid <= job.valid;
    end
    sum.red   <= chan_sum(red_v, rm, cm);
    sum.green <= chan_sum(green_v, rm, cm);
    sum.blue  <= chan_sum(blue_v, rm, cm);
    sum.n     <= 4'({2'b00, 2'($countones(rm))} * {2'b00, 2'($countones(cm))});
    sum.last  <= job.last;
    sum.done  <= !job.dc_off && !job.dr_off;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bb3_out_fifo.sv =====
`default_nettype none
module bb3_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bb3_pkg::sum_t sum,
  output logic               res_valid,
  input  wire logic          res_stall,
  output bb3_pkg::out_t      res
);

  bb3_pkg::out_t                fifo [bb3_pkg::FIFO_DEPTH];
  logic [bb3_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [bb3_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [bb3_pkg::CNT_W-1:0]    count;
  logic                         push;
  logic                         pop;
  bb3_pkg::out_t                entry;

  assign push = sum.valid;
  assign pop  = res_valid && !res_stall;

  always_comb begin
    entry.out_red    = bb3_pkg::mean_div(sum.red, sum.n);
    entry.out_green  = bb3_pkg::mean_div(sum.green, sum.n);
    entry.out_blue   = bb3_pkg::mean_div(sum.blue, sum.n);
    entry.run_last   = sum.last;
    entry.frame_done = sum.done;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bb3_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bb3_pkg::FIFO_AW'(1);
      end
      count <= count + bb3_pkg::CNT_W'(push) - bb3_pkg::CNT_W'(pop);
    end
  end

  assign res_valid = (count != '0);
  assign res       = fifo[rd_ptr];

endmodule
`default_nettype wire

// ===== tb/tb_box_blur_3x3_edge_normalized_top.sv =====
`timescale 1ns / 100ps

module tb_box_blur_3x3_edge_normalized_top;

  // register addresses: register index times four
  localparam logic [bb3_pkg::CFG_AW-1:0] ADDR_WIDTH  = {bb3_pkg::REG_FRAME_WIDTH, 2'b00};
  localparam logic [bb3_pkg::CFG_AW-1:0] ADDR_HEIGHT = {bb3_pkg::REG_FRAME_HEIGHT, 2'b00};

  // settling wait that covers any item still in flight
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PIXELS = 200;
  localparam int PLAN_LEN      = 27;

  typedef enum logic {ROW_SIZE, ROW_PIXEL} row_kind_e;
  typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_e;

  // one row of the directed table: either a frame size or a pixel
  typedef struct packed {
    row_kind_e     kind;
    logic [31:0]   width;
    logic [31:0]   height;
    bb3_pkg::in_t  px;
    logic          typed;
    bb3_pkg::out_t want;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bb3_pkg::CFG_AW-1:0] paddr;
  logic [bb3_pkg::APB_DW-1:0] pwdata;
  logic [bb3_pkg::APB_DW-1:0] prdata;
  logic                       pready;
  logic                       pix_valid;
  logic                       pix_stall;
  bb3_pkg::in_t               pix;
  logic                       res_valid;
  logic                       res_stall;
  bb3_pkg::out_t              res;

  // blur predictor state: two line stores, the 3x3 window and the raster position
  bb3_pkg::in_t              line_old [bb3_pkg::MAX_WIDTH];
  bb3_pkg::in_t              line_new [bb3_pkg::MAX_WIDTH];
  bb3_pkg::in_t              win [9];
  int                        row_at;
  int                        col_at;
  logic [bb3_pkg::DIM_W-1:0] cfg_width;
  logic [bb3_pkg::DIM_W-1:0] cfg_height;

  // results caused by the latest pixel, and all results still awaited
  bb3_pkg::out_t blur_burst [bb3_pkg::MAX_RESULTS];
  bb3_pkg::out_t blur_expected_q [$];

  logic        idle_on;
  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned sizes_run;

  box_blur_3x3_edge_normalized_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  // idle cycles before the next item on either side; none in burst stretches
  function automatic int unsigned gap_draw();
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  // channel value biased towards the extremes
  function automatic logic [7:0] chan_draw();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mean of one channel over the neighbours of (orow, ocol) inside the frame,
  // the centre sitting at window position (wr, wc), rounded half up
  function automatic logic [7:0] nbhd_mean(int orow, int ocol, int wr, int wc,
                                           int h, int w, chan_e ch);
    int           sum, n, dr, dc, ir, ic;
    bb3_pkg::in_t p;
    sum = 0;
    n   = 0;
    for (dr = -1; dr <= 1; dr++) begin
      ir = wr + dr;
      if (orow + dr < 0 || orow + dr >= h || ir < 0 || ir > 2) continue;
      for (dc = -1; dc <= 1; dc++) begin
        ic = wc + dc;
        if (ocol + dc < 0 || ocol + dc >= w || ic < 0 || ic > 2) continue;
        p = win[ir*3 + ic];
        case (ch)
          CH_RED:   sum += p.in_red;
          CH_GREEN: sum += p.in_green;
          default:  sum += p.in_blue;
        endcase
        n++;
      end
    end
    if (n == 0) return 8'd0;
    return 8'((2*sum + n) / (2*n));
  endfunction

  // advances the predictor by one pixel; results land in blur_burst
  function automatic int blur_predict(bb3_pkg::in_t px);
    int           w, h, r, c, col_lo, col_hi, row_lo, row_hi, oc, orow, i, count;
    bb3_pkg::in_t above2, above1;
    // width zero means 1, anything past the line store is clamped to it
    w = (cfg_width == 0) ? 1 :
        ((cfg_width > bb3_pkg::MAX_WIDTH) ? bb3_pkg::MAX_WIDTH : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    r = row_at;
    c = col_at;
    count = 0;
    above2 = line_old[c];
    above1 = line_new[c];
    line_old[c] = above1;
    line_new[c] = px;
    for (i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = above2;
    win[5] = above1;
    win[8] = px;
    // one column behind, plus the current column at a row end; likewise rows
    col_lo = (c >= 1) ? c - 1 : c;
    col_hi = (c + 1 == w) ? c : c - 1;
    row_lo = (r >= 1) ? r - 1 : r;
    row_hi = (r + 1 == h) ? r : r - 1;
    if ((c >= 1 || c + 1 == w) && (r >= 1 || r + 1 == h)) begin
      for (oc = col_lo; oc <= col_hi; oc++) begin
        for (orow = row_lo; orow <= row_hi; orow++) begin
          blur_burst[count].out_red    = nbhd_mean(orow, oc, 2 - (r - orow),
                                                   2 - (c - oc), h, w, CH_RED);
          blur_burst[count].out_green  = nbhd_mean(orow, oc, 2 - (r - orow),
                                                   2 - (c - oc), h, w, CH_GREEN);
          blur_burst[count].out_blue   = nbhd_mean(orow, oc, 2 - (r - orow),
                                                   2 - (c - oc), h, w, CH_BLUE);
          blur_burst[count].run_last   = 1'b0;
          blur_burst[count].frame_done = (orow + 1 == h && oc + 1 == w);
          count++;
        end
      end
    end
    if (count > 0) blur_burst[count - 1].run_last = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_at = c;
    row_at = r;
    return count;
  endfunction

  // apb write: setup phase, then access until pready, then back to idle
  task automatic reg_write(input logic [bb3_pkg::CFG_AW-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // any register write restarts the frame at the top-left pixel
    case (addr)
      ADDR_WIDTH:  cfg_width  = data[bb3_pkg::DIM_W-1:0];
      ADDR_HEIGHT: cfg_height = data[bb3_pkg::DIM_W-1:0];
      default: ;
    endcase
    row_at = 0;
    col_at = 0;
  endtask

  // apb read, prdata taken mid-cycle during the access phase
  task automatic reg_read_check(input logic [bb3_pkg::CFG_AW-1:0] addr,
                                input logic [bb3_pkg::DIM_W-1:0] want);
    logic [bb3_pkg::APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      got = prdata;
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== {{(bb3_pkg::APB_DW-bb3_pkg::DIM_W){1'b0}}, want}) begin
      $error("prdata at address %0d: expected %0d, got %0d", addr, want, got);
      mismatch_count++;
    end
  endtask

  // let the block go idle, then program a new frame size and read it back
  task automatic frame_setup(input logic [31:0] width_val, input logic [31:0] height_val);
    pix_valid <= 1'b0;
    while (blur_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(ADDR_WIDTH, width_val);
    reg_write(ADDR_HEIGHT, height_val);
    reg_read_check(ADDR_WIDTH, width_val[bb3_pkg::DIM_W-1:0]);
    reg_read_check(ADDR_HEIGHT, height_val[bb3_pkg::DIM_W-1:0]);
    sizes_run++;
  endtask

  // offers one pixel, holding valid across back-to-back items
  task automatic pixel_send(input bb3_pkg::in_t px, input logic typed,
                            input bb3_pkg::out_t want);
    int unsigned gap;
    int          n, i;
    gap = gap_draw();
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix       <= px;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    n = blur_predict(px);
    // a typed row stands for a pixel that causes exactly one result
    if (typed) begin
      blur_expected_q.push_back(want);
    end else begin
      for (i = 0; i < n; i++) blur_expected_q.push_back(blur_burst[i]);
    end
    pixels_sent++;
  endtask

  // one frame size with random pixels; count short of whole frames leaves
  // the frame broken off, to be restarted by the next register write
  task automatic frame_stream(input int unsigned cols, input int unsigned rows,
                              input int unsigned count);
    idle_on = ($urandom_range(0, 3) != 0);
    frame_setup(cols, rows);
    repeat (count) pixel_send({chan_draw(), chan_draw(), chan_draw()}, 1'b0, '0);
  endtask

  // result side: random stall per item, each result checked against the oldest
  // expectation
  initial begin : result_sink
    int unsigned   hold;
    bb3_pkg::out_t want;
    hold = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) begin
        results_seen++;
        if (blur_expected_q.size() == 0) begin
          $error("result %h arrived with nothing expected", res);
          mismatch_count++;
        end else begin
          want = blur_expected_q.pop_front();
          if (res.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, res.out_red);
            mismatch_count++;
          end
          if (res.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, res.out_green);
            mismatch_count++;
          end
          if (res.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, res.out_blue);
            mismatch_count++;
          end
          if (res.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, res.run_last);
            mismatch_count++;
          end
          if (res.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, res.frame_done);
            mismatch_count++;
          end
        end
        hold = gap_draw();
        res_stall <= (hold != 0);
      end else if (hold != 0) begin
        hold--;
        res_stall <= (hold != 0);
      end
    end
  end

  initial begin : stimulus
    stim_row_t   stim_plan [PLAN_LEN];
    int unsigned rand_pixels, cols, rows, count;

    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    pix_valid <= 1'b0;
    pix       <= '0;

    // predictor reset: stores and window cleared, default 640 x 480 frame
    foreach (line_old[i]) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    row_at = 0;
    col_at = 0;
    cfg_width  = bb3_pkg::WIDTH_RESET;
    cfg_height = bb3_pkg::HEIGHT_RESET;
    idle_on = 1'b1;
    mismatch_count = 0;
    pixels_sent    = 0;
    results_seen   = 0;
    sizes_run      = 0;

    // a single-pixel frame gives back the pixel itself, last and done set
    stim_plan = '{
      '{ROW_SIZE,  32'd1, 32'd1, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h000000, 1'b1, {24'h000000, 2'b11}},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hFFFFFF, 1'b1, {24'hFFFFFF, 2'b11}},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hFF0000, 1'b1, {24'hFF0000, 2'b11}},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h00FF00, 1'b1, {24'h00FF00, 2'b11}},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h0000FF, 1'b1, {24'h0000FF, 2'b11}},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h5AA55A, 1'b1, {24'h5AA55A, 2'b11}},
      // zero width and zero height both fall back to 1
      '{ROW_SIZE,  32'd0, 32'd0, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hA5C33C, 1'b1, {24'hA5C33C, 2'b11}},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h123456, 1'b1, {24'h123456, 2'b11}},
      // 3 x 3 frame, upper bits of the width write ignored; corners, edges, centre
      '{ROW_SIZE,  32'hFFFF_F003, 32'd3, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hFFFFFF, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hFFFFFF, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hFFFFFF, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h807F01, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h01FE80, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'hFF00FF, 1'b0, 26'h0},
      // one-row frame: a mean of exactly one half rounds up
      '{ROW_SIZE,  32'd2, 32'd1, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h010101, 1'b0, 26'h0},
      // one-column frame
      '{ROW_SIZE,  32'd1, 32'd3, 24'h000000, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h102030, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h405060, 1'b0, 26'h0},
      '{ROW_PIXEL, 32'd0, 32'd0, 24'h708090, 1'b0, 26'h0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of both registers
    reg_read_check(ADDR_WIDTH, bb3_pkg::WIDTH_RESET);
    reg_read_check(ADDR_HEIGHT, bb3_pkg::HEIGHT_RESET);

    foreach (stim_plan[i]) begin
      if (stim_plan[i].kind == ROW_SIZE) begin
        frame_setup(stim_plan[i].width, stim_plan[i].height);
      end else begin
        pixel_send(stim_plan[i].px, stim_plan[i].typed, stim_plan[i].want);
      end
    end

    // small random frames, mostly whole, some broken off part way; the last
    // one is cut short where the pixel budget runs out
    rand_pixels = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      cols  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      rows  = $urandom_range(1, 6);
      count = cols * rows * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_PIXELS - rand_pixels) count = RANDOM_PIXELS - rand_pixels;
      frame_stream(cols, rows, count);
      rand_pixels += count;
    end

    pix_valid <= 1'b0;
    while (blur_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("blur check: %0d pixels over %0d frame sizes, %0d results compared",
             pixels_sent, sizes_run, results_seen);
    $display("sizes ran from a single pixel up to 40 wide and 6 high, some cut short");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin : run_limit
    #25_000_000;
    $display("timeout with %0d results still awaited", blur_expected_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
